@@ design/pid_antiwindup_controller_assert.svh @@
// Assertion macros for the checker module.
`ifndef PID_ANTIWINDUP_CONTROLLER_ASSERT_SVH
`define PID_ANTIWINDUP_CONTROLLER_ASSERT_SVH

// Clocked property, disabled while reset is high.
`define PIDAW_ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Property that must follow a cycle in which a channel is stalled.
`define PIDAW_ASSERT_STALL(lbl, vld, rdy, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (vld && !rdy) |=> expr) \
      else $error(msg);

`endif

@@ design/pidaw_pkg.sv @@
package pidaw_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int DATA_W       = 32;
   localparam int ERR_W        = SAMPLE_WIDTH + 1;
   localparam int DER_W        = SAMPLE_WIDTH + 2;
   localparam int PE_W         = DATA_W + ERR_W;
   localparam int DE_W         = DATA_W + DER_W;
   localparam int PD_W         = DE_W + 1;
   localparam int LAW_W        = 2 * DATA_W;
   localparam int WIDE_W       = DATA_W + 1;
   localparam int MODE_W       = 3;
   localparam int CSR_INDEX_W  = 3;

   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PROP_GAIN    = 3'd0,
      CSR_INTEG_GAIN   = 3'd1,
      CSR_DERIV_GAIN   = 3'd2,
      CSR_EFFORT_UPPER = 3'd3,
      CSR_EFFORT_LOWER = 3'd4,
      CSR_SUM_UPPER    = 3'd5,
      CSR_SUM_LOWER    = 3'd6,
      CSR_CONTROL_MODE = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      WINDUP_NONE  = 2'd0,
      WINDUP_COND  = 2'd1,
      WINDUP_CLAMP = 2'd2
   } windup_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] prop_gain;
      logic signed [DATA_W-1:0] integ_gain;
      logic signed [DATA_W-1:0] deriv_gain;
      logic signed [DATA_W-1:0] effort_upper;
      logic signed [DATA_W-1:0] effort_lower;
      logic signed [DATA_W-1:0] sum_upper;
      logic signed [DATA_W-1:0] sum_lower;
      logic [MODE_W-1:0]        control_mode;
   } cfg_type;

endpackage

@@ design/pidaw_csr.sv @@
module pidaw_csr (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [pidaw_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [pidaw_pkg::DATA_W-1:0]            csr_wdata,
   output pidaw_pkg::cfg_type                      cfg
);

   pidaw_pkg::cfg_type cfg_ff;
   pidaw_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (pidaw_pkg::csr_index_type'(csr_index))
            pidaw_pkg::CSR_PROP_GAIN:    cfg_in.prop_gain    = csr_wdata;
            pidaw_pkg::CSR_INTEG_GAIN:   cfg_in.integ_gain   = csr_wdata;
            pidaw_pkg::CSR_DERIV_GAIN:   cfg_in.deriv_gain   = csr_wdata;
            pidaw_pkg::CSR_EFFORT_UPPER: cfg_in.effort_upper = csr_wdata;
            pidaw_pkg::CSR_EFFORT_LOWER: cfg_in.effort_lower = csr_wdata;
            pidaw_pkg::CSR_SUM_UPPER:    cfg_in.sum_upper    = csr_wdata;
            pidaw_pkg::CSR_SUM_LOWER:    cfg_in.sum_lower    = csr_wdata;
            pidaw_pkg::CSR_CONTROL_MODE: cfg_in.control_mode = csr_wdata[pidaw_pkg::MODE_W-1:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain    <= '0;
         cfg_ff.integ_gain   <= '0;
         cfg_ff.deriv_gain   <= '0;
         cfg_ff.effort_upper <= pidaw_pkg::DATA_MAX;
         cfg_ff.effort_lower <= pidaw_pkg::DATA_MIN;
         cfg_ff.sum_upper    <= pidaw_pkg::DATA_MAX;
         cfg_ff.sum_lower    <= pidaw_pkg::DATA_MIN;
         cfg_ff.control_mode <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ design/pidaw_front.sv @@
module pidaw_front (
   input  logic                                          clock,
   input  logic                                          reset,
   input  pidaw_pkg::cfg_type                            cfg,
   input  logic                                          req_valid,
   output logic                                          req_ready,
   input  logic signed [pidaw_pkg::SAMPLE_WIDTH-1:0]     req_setpoint,
   input  logic signed [pidaw_pkg::SAMPLE_WIDTH-1:0]     req_feedback,
   output logic                                          pd_valid,
   input  logic                                          pd_ready,
   output logic signed [pidaw_pkg::ERR_W-1:0]            pd_err,
   output logic signed [pidaw_pkg::PD_W-1:0]             pd_sum
);

   logic                                       in_valid_ff;
   logic signed [pidaw_pkg::SAMPLE_WIDTH-1:0]  setpoint_ff;
   logic signed [pidaw_pkg::SAMPLE_WIDTH-1:0]  feedback_ff;
   logic signed [pidaw_pkg::ERR_W-1:0]         last_err_ff;

   logic                                       s1_valid_ff;
   logic signed [pidaw_pkg::ERR_W-1:0]         err1_ff;
   logic signed [pidaw_pkg::PE_W-1:0]          pe_ff;
   logic signed [pidaw_pkg::DE_W-1:0]          de_ff;

   logic                                       pd_valid_ff;
   logic signed [pidaw_pkg::ERR_W-1:0]         err2_ff;
   logic signed [pidaw_pkg::PD_W-1:0]          pd_ff;

   logic                                       s1_rdy;
   logic                                       s2_rdy;
   logic signed [pidaw_pkg::DATA_W-1:0]        prop_gain;
   logic signed [pidaw_pkg::DATA_W-1:0]        deriv_gain;
   logic signed [pidaw_pkg::ERR_W-1:0]         err_in;
   logic signed [pidaw_pkg::DER_W-1:0]         der_in;
   logic signed [pidaw_pkg::PE_W-1:0]          pe_in;
   logic signed [pidaw_pkg::DE_W-1:0]          de_in;
   logic signed [pidaw_pkg::PD_W-1:0]          pd_in;

   assign prop_gain  = cfg.prop_gain;
   assign deriv_gain = cfg.deriv_gain;

   assign s2_rdy    = !pd_valid_ff || pd_ready;
   assign s1_rdy    = !s1_valid_ff || s2_rdy;
   assign req_ready = !in_valid_ff || s1_rdy;

   assign err_in = pidaw_pkg::ERR_W'(setpoint_ff) - pidaw_pkg::ERR_W'(feedback_ff);
   assign der_in = pidaw_pkg::DER_W'(err_in) - pidaw_pkg::DER_W'(last_err_ff);
   assign pe_in  = pidaw_pkg::PE_W'(prop_gain * err_in);
   assign de_in  = pidaw_pkg::DE_W'(deriv_gain * der_in);
   assign pd_in  = pidaw_pkg::PD_W'(pe_ff) + pidaw_pkg::PD_W'(de_ff);

   assign pd_valid = pd_valid_ff;
   assign pd_err   = err2_ff;
   assign pd_sum   = pd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         pd_valid_ff <= 1'b0;
         last_err_ff <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (s1_rdy) begin
            s1_valid_ff <= in_valid_ff;
         end
         if (s2_rdy) begin
            pd_valid_ff <= s1_valid_ff;
         end
         if (in_valid_ff && s1_rdy) begin
            last_err_ff <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         setpoint_ff <= req_setpoint;
         feedback_ff <= req_feedback;
      end
      if (in_valid_ff && s1_rdy) begin
         err1_ff <= err_in;
         pe_ff   <= pe_in;
         de_ff   <= de_in;
      end
      if (s1_valid_ff && s2_rdy) begin
         err2_ff <= err1_ff;
         pd_ff   <= pd_in;
      end
   end

endmodule

@@ design/pidaw_integ.sv @@
module pidaw_integ (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pidaw_pkg::cfg_type                    cfg,
   input  logic                                  pd_valid,
   output logic                                  pd_ready,
   input  logic signed [pidaw_pkg::ERR_W-1:0]    pd_err,
   input  logic signed [pidaw_pkg::PD_W-1:0]     pd_sum,
   output logic                                  sum_valid,
   input  logic                                  sum_ready,
   output logic signed [pidaw_pkg::DATA_W-1:0]   sum_value,
   output logic signed [pidaw_pkg::PD_W-1:0]     sum_pd
);

   logic signed [pidaw_pkg::DATA_W-1:0]  error_sum_ff;
   logic                                 sum_valid_ff;
   logic signed [pidaw_pkg::DATA_W-1:0]  sum_value_ff;
   logic signed [pidaw_pkg::PD_W-1:0]    sum_pd_ff;

   logic                                 sum_rdy;
   logic signed [pidaw_pkg::DATA_W-1:0]  integ_gain;
   logic signed [pidaw_pkg::DATA_W-1:0]  sum_upper;
   logic signed [pidaw_pkg::DATA_W-1:0]  sum_lower;
   logic signed [pidaw_pkg::WIDE_W-1:0]  wide_in;
   logic signed [pidaw_pkg::DATA_W-1:0]  pros_in;
   logic signed [pidaw_pkg::LAW_W-1:0]   kip_in;
   logic signed [pidaw_pkg::LAW_W-1:0]   try_in;
   logic signed [pidaw_pkg::LAW_W-1:0]   up_in;
   logic signed [pidaw_pkg::LAW_W-1:0]   lo_in;
   logic                                 err_neg;
   logic                                 err_pos;
   logic                                 keep_in;
   logic signed [pidaw_pkg::DATA_W-1:0]  sum_in;

   assign integ_gain = cfg.integ_gain;
   assign sum_upper  = cfg.sum_upper;
   assign sum_lower  = cfg.sum_lower;
   assign up_in      = pidaw_pkg::LAW_W'(cfg.effort_upper);
   assign lo_in      = pidaw_pkg::LAW_W'(cfg.effort_lower);

   assign sum_rdy  = !sum_valid_ff || sum_ready;
   assign pd_ready = sum_rdy;

   assign wide_in = pidaw_pkg::WIDE_W'(error_sum_ff) + pidaw_pkg::WIDE_W'(pd_err);

   always_comb begin
      if (wide_in[pidaw_pkg::DATA_W] != wide_in[pidaw_pkg::DATA_W-1]) begin
         pros_in = wide_in[pidaw_pkg::DATA_W] ? pidaw_pkg::DATA_MIN : pidaw_pkg::DATA_MAX;
      end else begin
         pros_in = wide_in[pidaw_pkg::DATA_W-1:0];
      end
   end

   assign kip_in  = pidaw_pkg::LAW_W'(integ_gain * pros_in);
   assign try_in  = kip_in + pidaw_pkg::LAW_W'(pd_sum);
   assign err_neg = pd_err[pidaw_pkg::ERR_W-1];
   assign err_pos = !err_neg && (pd_err != '0);
   assign keep_in = ((lo_in < try_in) && (try_in < up_in))
                 || (err_neg && (try_in > up_in))
                 || (err_pos && (try_in < lo_in));

   always_comb begin
      unique case (pidaw_pkg::windup_type'(cfg.control_mode[pidaw_pkg::MODE_W-1:1]))
         pidaw_pkg::WINDUP_COND: begin
            sum_in = keep_in ? pros_in : error_sum_ff;
         end
         pidaw_pkg::WINDUP_CLAMP: begin
            if (pros_in > sum_upper) begin
               sum_in = sum_upper;
            end else if (pros_in < sum_lower) begin
               sum_in = sum_lower;
            end else begin
               sum_in = pros_in;
            end
         end
         pidaw_pkg::WINDUP_NONE: sum_in = pros_in;
         default:                sum_in = pros_in;
      endcase
   end

   assign sum_valid = sum_valid_ff;
   assign sum_value = sum_value_ff;
   assign sum_pd    = sum_pd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         error_sum_ff <= '0;
      end else begin
         if (sum_rdy) begin
            sum_valid_ff <= pd_valid;
         end
         if (pd_valid && sum_rdy) begin
            error_sum_ff <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pd_valid && sum_rdy) begin
         sum_value_ff <= sum_in;
         sum_pd_ff    <= pd_sum;
      end
   end

endmodule

@@ design/pidaw_out.sv @@
module pidaw_out (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pidaw_pkg::cfg_type                    cfg,
   input  logic                                  sum_valid,
   output logic                                  sum_ready,
   input  logic signed [pidaw_pkg::DATA_W-1:0]   sum_value,
   input  logic signed [pidaw_pkg::PD_W-1:0]     sum_pd,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [pidaw_pkg::DATA_W-1:0]   rsp_effort
);

   logic                                 prod_valid_ff;
   logic signed [pidaw_pkg::LAW_W-1:0]   kis_ff;
   logic signed [pidaw_pkg::PD_W-1:0]    pd_ff;
   logic                                 rsp_valid_ff;
   logic signed [pidaw_pkg::DATA_W-1:0]  effort_ff;

   logic                                 s4_rdy;
   logic                                 out_rdy;
   logic signed [pidaw_pkg::DATA_W-1:0]  integ_gain;
   logic signed [pidaw_pkg::LAW_W-1:0]   kis_in;
   logic signed [pidaw_pkg::LAW_W-1:0]   law_in;
   logic signed [pidaw_pkg::LAW_W-1:0]   lim_in;
   logic signed [pidaw_pkg::LAW_W-1:0]   up_in;
   logic signed [pidaw_pkg::LAW_W-1:0]   lo_in;
   logic signed [pidaw_pkg::LAW_W-1:0]   max_in;
   logic signed [pidaw_pkg::LAW_W-1:0]   min_in;
   logic signed [pidaw_pkg::DATA_W-1:0]  effort_in;

   assign integ_gain = cfg.integ_gain;
   assign up_in      = pidaw_pkg::LAW_W'(cfg.effort_upper);
   assign lo_in      = pidaw_pkg::LAW_W'(cfg.effort_lower);
   assign max_in     = pidaw_pkg::LAW_W'(pidaw_pkg::DATA_MAX);
   assign min_in     = pidaw_pkg::LAW_W'(pidaw_pkg::DATA_MIN);

   assign out_rdy   = !rsp_valid_ff || rsp_ready;
   assign s4_rdy    = !prod_valid_ff || out_rdy;
   assign sum_ready = s4_rdy;

   assign kis_in = pidaw_pkg::LAW_W'(integ_gain * sum_value);
   assign law_in = kis_ff + pidaw_pkg::LAW_W'(pd_ff);

   always_comb begin
      lim_in = law_in;
      if (cfg.control_mode[0]) begin
         if (law_in > up_in) begin
            lim_in = up_in;
         end else if (law_in < lo_in) begin
            lim_in = lo_in;
         end
      end
      if (lim_in > max_in) begin
         effort_in = pidaw_pkg::DATA_MAX;
      end else if (lim_in < min_in) begin
         effort_in = pidaw_pkg::DATA_MIN;
      end else begin
         effort_in = lim_in[pidaw_pkg::DATA_W-1:0];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_effort = effort_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (s4_rdy) begin
            prod_valid_ff <= sum_valid;
         end
         if (out_rdy) begin
            rsp_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sum_valid && s4_rdy) begin
         kis_ff <= kis_in;
         pd_ff  <= sum_pd;
      end
      if (prod_valid_ff && out_rdy) begin
         effort_ff <= effort_in;
      end
   end

endmodule

@@ design/pid_antiwindup_controller.sv @@
// Channel   Handshake               Payload
// req       req_valid / req_ready   req_setpoint, req_feedback (signed samples)
// rsp       rsp_valid / rsp_ready   rsp_effort (signed Q16.16)
// csr       csr_valid / csr_ready   csr_index, csr_wdata
//
// One transaction is accepted per cycle unless a stalled output backs up the
// pipeline; each result comes from a six-register pipeline.
// The error-sum update closes its loop in the integrator stage: a saturating
// add, one 32x32 multiply and the windup compare share that cycle.
// Reset clears the pipeline, the previous error and the error sum, and loads
// the register defaults. A stage holds only while the stage after it is full
// and stalled, so input transactions keep flowing into empty stages.
module pid_antiwindup_controller (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_valid,
   output logic                                          req_ready,
   input  logic signed [pidaw_pkg::SAMPLE_WIDTH-1:0]     req_setpoint,
   input  logic signed [pidaw_pkg::SAMPLE_WIDTH-1:0]     req_feedback,
   output logic                                          rsp_valid,
   input  logic                                          rsp_ready,
   output logic signed [pidaw_pkg::DATA_W-1:0]           rsp_effort,
   input  logic                                          csr_valid,
   output logic                                          csr_ready,
   input  logic [pidaw_pkg::CSR_INDEX_W-1:0]             csr_index,
   input  logic [pidaw_pkg::DATA_W-1:0]                  csr_wdata
);

   pidaw_pkg::cfg_type                   cfg;
   logic                                 pd_valid;
   logic                                 pd_ready;
   logic signed [pidaw_pkg::ERR_W-1:0]   pd_err;
   logic signed [pidaw_pkg::PD_W-1:0]    pd_sum;
   logic                                 sum_valid;
   logic                                 sum_ready;
   logic signed [pidaw_pkg::DATA_W-1:0]  sum_value;
   logic signed [pidaw_pkg::PD_W-1:0]    sum_pd;

   pidaw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pidaw_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_setpoint (req_setpoint),
      .req_feedback (req_feedback),
      .pd_valid     (pd_valid),
      .pd_ready     (pd_ready),
      .pd_err       (pd_err),
      .pd_sum       (pd_sum)
   );

   pidaw_integ u_integ (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pd_valid  (pd_valid),
      .pd_ready  (pd_ready),
      .pd_err    (pd_err),
      .pd_sum    (pd_sum),
      .sum_valid (sum_valid),
      .sum_ready (sum_ready),
      .sum_value (sum_value),
      .sum_pd    (sum_pd)
   );

   pidaw_out u_out (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .sum_valid  (sum_valid),
      .sum_ready  (sum_ready),
      .sum_value  (sum_value),
      .sum_pd     (sum_pd),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_effort (rsp_effort)
   );

endmodule

@@ design/pidaw_checker.sv @@
`include "pid_antiwindup_controller_assert.svh"

module pidaw_checker (
   input logic                                      clock,
   input logic                                      reset,
   input logic                                      req_valid,
   input logic                                      req_ready,
   input logic                                      rsp_valid,
   input logic                                      rsp_ready,
   input logic signed [pidaw_pkg::DATA_W-1:0]       rsp_effort,
   input logic                                      csr_valid,
   input logic                                      csr_ready,
   input logic [pidaw_pkg::CSR_INDEX_W-1:0]         csr_index,
   input logic [pidaw_pkg::DATA_W-1:0]              csr_wdata
);

   logic [3:0]                           pending_ff;
   logic [3:0]                           pending_in;
   logic signed [pidaw_pkg::DATA_W-1:0]  upper_ff;
   logic signed [pidaw_pkg::DATA_W-1:0]  lower_ff;
   logic                                 clamp_ff;
   logic                                 csr_write;

   assign csr_write  = csr_valid && csr_ready;
   assign pending_in = pending_ff + 4'(req_valid && req_ready) - 4'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         upper_ff   <= pidaw_pkg::DATA_MAX;
         lower_ff   <= pidaw_pkg::DATA_MIN;
         clamp_ff   <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         if (csr_write && (csr_index == pidaw_pkg::CSR_EFFORT_UPPER)) begin
            upper_ff <= csr_wdata;
         end
         if (csr_write && (csr_index == pidaw_pkg::CSR_EFFORT_LOWER)) begin
            lower_ff <= csr_wdata;
         end
         if (csr_write && (csr_index == pidaw_pkg::CSR_CONTROL_MODE)) begin
            clamp_ff <= csr_wdata[0];
         end
      end
   end

   `PIDAW_ASSERT_STALL(rsp_valid_held, rsp_valid, rsp_ready, rsp_valid, "rsp_valid dropped while stalled")
   `PIDAW_ASSERT_STALL(rsp_effort_held, rsp_valid, rsp_ready, $stable(rsp_effort), "rsp_effort changed while stalled")
   `PIDAW_ASSERT_CLK(rsp_needs_request, rsp_valid |-> (pending_ff != 4'd0), "result without an accepted transaction")
   `PIDAW_ASSERT_CLK(ready_when_empty, (pending_ff == 4'd0) |-> req_ready, "req_ready low with an empty pipeline")
   `PIDAW_ASSERT_CLK(effort_in_limits, (rsp_valid && clamp_ff && (lower_ff <= upper_ff)) |-> ((rsp_effort <= upper_ff) && (rsp_effort >= lower_ff)), "clamped effort outside its limits")

endmodule

bind pid_antiwindup_controller pidaw_checker u_checker (.*);

@@ tb/tb_pid_antiwindup_controller.sv @@
`timescale 1ns / 1ps

module tb_pid_antiwindup_controller;

   localparam logic [1:0] WINDUP_UNUSED = 2'd3;
   localparam logic signed [pidaw_pkg::SAMPLE_WIDTH-1:0] SAMPLE_MAX =
      {1'b0, {(pidaw_pkg::SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [pidaw_pkg::SAMPLE_WIDTH-1:0] SAMPLE_MIN =
      {1'b1, {(pidaw_pkg::SAMPLE_WIDTH-1){1'b0}}};
   localparam int EFFORT_SPAN = 32'h0800_0000;
   localparam int SUM_SPAN    = 100000;
   localparam int PHASE_ITEMS = 48;

   typedef struct {
      bit                                         is_cfg;
      pidaw_pkg::csr_index_type                   reg_index;
      logic [pidaw_pkg::DATA_W-1:0]               data;
      logic signed [pidaw_pkg::SAMPLE_WIDTH-1:0]  setpoint;
      logic signed [pidaw_pkg::SAMPLE_WIDTH-1:0]  feedback;
      bit                                         known;
      logic signed [pidaw_pkg::DATA_W-1:0]        effort;
   } drill_row_type;

   logic                                       clock;
   logic                                       reset;
   logic                                       req_valid;
   logic                                       req_ready;
   logic signed [pidaw_pkg::SAMPLE_WIDTH-1:0]  req_setpoint;
   logic signed [pidaw_pkg::SAMPLE_WIDTH-1:0]  req_feedback;
   logic                                       rsp_valid;
   logic                                       rsp_ready;
   logic signed [pidaw_pkg::DATA_W-1:0]        rsp_effort;
   logic                                       csr_valid;
   logic                                       csr_ready;
   logic [pidaw_pkg::CSR_INDEX_W-1:0]          csr_index;
   logic [pidaw_pkg::DATA_W-1:0]               csr_wdata;

   pidaw_pkg::cfg_type                   pid_cfg;
   logic signed [pidaw_pkg::ERR_W-1:0]   prev_error;
   logic signed [pidaw_pkg::DATA_W-1:0]  integ_sum;
   logic signed [pidaw_pkg::DATA_W-1:0]  effort_q[$];
   drill_row_type                        drill_rows[$];
   int                                   fail_count = 0;
   int                                   send_gap_pct = 12;
   int                                   rsp_stall_pct = 49;
   int                                   rsp_hold_cycles = 0;

   pid_antiwindup_controller uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_setpoint(req_setpoint),
      .req_feedback(req_feedback),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_effort(rsp_effort),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAIL pid_antiwindup_controller");
      $finish;
   end

   function automatic longint saturate_data(input longint v);
      if (v > longint'(pidaw_pkg::DATA_MAX)) return longint'(pidaw_pkg::DATA_MAX);
      if (v < longint'(pidaw_pkg::DATA_MIN)) return longint'(pidaw_pkg::DATA_MIN);
      return v;
   endfunction

   function automatic longint control_law(input longint e, input longint s, input longint d);
      return longint'($signed(pid_cfg.prop_gain)) * e
           + longint'($signed(pid_cfg.integ_gain)) * s
           + longint'($signed(pid_cfg.deriv_gain)) * d;
   endfunction

   function automatic logic [pidaw_pkg::DATA_W-1:0] mode_word(input logic [1:0] windup,
                                                             input bit clamp);
      return pidaw_pkg::DATA_W'({windup, clamp});
   endfunction

   // Advances the controller state by one sample pair and returns the effort.
   function automatic logic signed [pidaw_pkg::DATA_W-1:0] pid_effort_step(
      input logic signed [pidaw_pkg::SAMPLE_WIDTH-1:0] sp,
      input logic signed [pidaw_pkg::SAMPLE_WIDTH-1:0] fb);
      longint err, der, pros, sum, u_try, u, up, lo;
      logic [1:0] windup;
      bit keep;
      err = longint'(sp) - longint'(fb);
      der = err - longint'(prev_error);
      pros = saturate_data(longint'(integ_sum) + err);
      up = longint'($signed(pid_cfg.effort_upper));
      lo = longint'($signed(pid_cfg.effort_lower));
      windup = pid_cfg.control_mode[2:1];
      prev_error = err[pidaw_pkg::ERR_W-1:0];
      case (windup)
         pidaw_pkg::WINDUP_COND: begin
            u_try = control_law(err, pros, der);
            keep = (lo < u_try && u_try < up) || (err < 0 && u_try > up)
                || (err > 0 && u_try < lo);
            sum = keep ? pros : longint'(integ_sum);
         end
         pidaw_pkg::WINDUP_CLAMP: begin
            sum = pros;
            if (sum > longint'($signed(pid_cfg.sum_upper))) begin
               sum = longint'($signed(pid_cfg.sum_upper));
            end else if (sum < longint'($signed(pid_cfg.sum_lower))) begin
               sum = longint'($signed(pid_cfg.sum_lower));
            end
         end
         default: sum = pros;
      endcase
      integ_sum = sum[pidaw_pkg::DATA_W-1:0];
      u = control_law(err, sum, der);
      if (pid_cfg.control_mode[0]) begin
         if (u > up) u = up;
         else if (u < lo) u = lo;
      end
      u = saturate_data(u);
      return u[pidaw_pkg::DATA_W-1:0];
   endfunction

   function automatic void apply_cfg(input pidaw_pkg::csr_index_type idx,
                                     input logic [pidaw_pkg::DATA_W-1:0] data);
      case (idx)
         pidaw_pkg::CSR_PROP_GAIN:    pid_cfg.prop_gain = data;
         pidaw_pkg::CSR_INTEG_GAIN:   pid_cfg.integ_gain = data;
         pidaw_pkg::CSR_DERIV_GAIN:   pid_cfg.deriv_gain = data;
         pidaw_pkg::CSR_EFFORT_UPPER: pid_cfg.effort_upper = data;
         pidaw_pkg::CSR_EFFORT_LOWER: pid_cfg.effort_lower = data;
         pidaw_pkg::CSR_SUM_UPPER:    pid_cfg.sum_upper = data;
         pidaw_pkg::CSR_SUM_LOWER:    pid_cfg.sum_lower = data;
         pidaw_pkg::CSR_CONTROL_MODE: pid_cfg.control_mode = data[pidaw_pkg::MODE_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic drill_row_type cfg_row(input pidaw_pkg::csr_index_type idx,
                                             input logic [pidaw_pkg::DATA_W-1:0] data);
      drill_row_type r;
      r.is_cfg = 1'b1;
      r.reg_index = idx;
      r.data = data;
      r.setpoint = '0;
      r.feedback = '0;
      r.known = 1'b0;
      r.effort = '0;
      return r;
   endfunction

   function automatic drill_row_type item_row(
      input logic signed [pidaw_pkg::SAMPLE_WIDTH-1:0] sp,
      input logic signed [pidaw_pkg::SAMPLE_WIDTH-1:0] fb,
      input bit known,
      input logic signed [pidaw_pkg::DATA_W-1:0] effort);
      drill_row_type r;
      r.is_cfg = 1'b0;
      r.reg_index = pidaw_pkg::CSR_PROP_GAIN;
      r.data = '0;
      r.setpoint = sp;
      r.feedback = fb;
      r.known = known;
      r.effort = effort;
      return r;
   endfunction

   function automatic logic signed [pidaw_pkg::SAMPLE_WIDTH-1:0] rand_sample();
      case ($urandom_range(9))
         0: return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
         1, 2, 3: return pidaw_pkg::SAMPLE_WIDTH'($urandom());
         default: return pidaw_pkg::SAMPLE_WIDTH'(int'($urandom_range(600)) - 300);
      endcase
   endfunction

   function automatic logic [pidaw_pkg::DATA_W-1:0] rand_gain();
      logic [pidaw_pkg::DATA_W-1:0] r;
      case ($urandom_range(7))
         0: return '0;
         1: return $urandom_range(1) ? pidaw_pkg::DATA_MAX : pidaw_pkg::DATA_MIN;
         2: return $urandom();
         default: begin
            r = $urandom_range(32'h40000);
            return $urandom_range(1) ? r : -r;
         end
      endcase
   endfunction

   function automatic void rand_limits(input int span,
                                       output logic signed [pidaw_pkg::DATA_W-1:0] upper,
                                       output logic signed [pidaw_pkg::DATA_W-1:0] lower);
      logic signed [pidaw_pkg::DATA_W-1:0] a, b;
      case ($urandom_range(5))
         0: begin
            upper = pidaw_pkg::DATA_MAX;
            lower = pidaw_pkg::DATA_MIN;
         end
         1: begin
            upper = $urandom();
            lower = $urandom();
         end
         default: begin
            a = $urandom_range(span);
            b = $urandom_range(span);
            if ($urandom_range(1)) a = -a;
            if ($urandom_range(1)) b = -b;
            // Occasionally the limits are crossed on purpose.
            if ((a >= b) == ($urandom_range(4) != 0)) begin
               upper = a;
               lower = b;
            end else begin
               upper = b;
               lower = a;
            end
         end
      endcase
   endfunction

   task automatic send_sample(input logic signed [pidaw_pkg::SAMPLE_WIDTH-1:0] sp,
                              input logic signed [pidaw_pkg::SAMPLE_WIDTH-1:0] fb,
                              input bit known = 1'b0,
                              input logic signed [pidaw_pkg::DATA_W-1:0] fixed = '0);
      logic signed [pidaw_pkg::DATA_W-1:0] predicted;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_setpoint <= sp;
      req_feedback <= fb;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predicted = pid_effort_step(sp, fb);
      effort_q.push_back(known ? fixed : predicted);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (effort_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(input pidaw_pkg::csr_index_type idx,
                            input logic [pidaw_pkg::DATA_W-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      apply_cfg(idx, data);
      @(negedge clock);
   endtask

   task automatic run_random_phase(input int n_items, input bit hold_rsp, input bit mid_pause);
      logic signed [pidaw_pkg::DATA_W-1:0] up_v, lo_v;
      wait_idle();
      write_csr(pidaw_pkg::CSR_PROP_GAIN, rand_gain());
      write_csr(pidaw_pkg::CSR_INTEG_GAIN, rand_gain());
      write_csr(pidaw_pkg::CSR_DERIV_GAIN, rand_gain());
      rand_limits(EFFORT_SPAN, up_v, lo_v);
      write_csr(pidaw_pkg::CSR_EFFORT_UPPER, up_v);
      write_csr(pidaw_pkg::CSR_EFFORT_LOWER, lo_v);
      rand_limits(SUM_SPAN, up_v, lo_v);
      write_csr(pidaw_pkg::CSR_SUM_UPPER, up_v);
      write_csr(pidaw_pkg::CSR_SUM_LOWER, lo_v);
      write_csr(pidaw_pkg::CSR_CONTROL_MODE, $urandom());
      csr_valid <= 1'b0;
      for (int i = 0; i < n_items; i++) begin
         // A long receiver stall lets the pipeline fill and back up the input.
         if (hold_rsp && i == 8) rsp_hold_cycles = 60;
         if (mid_pause && i == n_items / 2) wait_idle();
         send_sample(rand_sample(), rand_sample());
      end
   endtask

   initial begin : rsp_driver
      int n;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            n = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : effort_check
      logic signed [pidaw_pkg::DATA_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (effort_q.size() == 0) begin
            $error("effort: no transaction expected, actual %0d", rsp_effort);
            fail_count++;
         end else begin
            want = effort_q.pop_front();
            if (rsp_effort !== want) begin
               $error("effort: expected %0d, actual %0d", want, rsp_effort);
               fail_count++;
            end
         end
      end
   end

   initial begin : stimulus
      bit cfg_open;
      reset = 1'b1;
      req_valid = 1'b0;
      req_setpoint = '0;
      req_feedback = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      pid_cfg.prop_gain = '0;
      pid_cfg.integ_gain = '0;
      pid_cfg.deriv_gain = '0;
      pid_cfg.effort_upper = pidaw_pkg::DATA_MAX;
      pid_cfg.effort_lower = pidaw_pkg::DATA_MIN;
      pid_cfg.sum_upper = pidaw_pkg::DATA_MAX;
      pid_cfg.sum_lower = pidaw_pkg::DATA_MIN;
      pid_cfg.control_mode = '0;
      prev_error = '0;
      integ_sum = '0;
      cfg_open = 1'b0;

      // All gains are zero after reset.
      drill_rows.push_back(item_row(SAMPLE_MAX, SAMPLE_MIN, 1'b1, '0));
      drill_rows.push_back(item_row(SAMPLE_MIN, SAMPLE_MAX, 1'b1, '0));
      // Unity proportional gain saturates at the widest errors.
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_PROP_GAIN, 32'h0001_0000));
      drill_rows.push_back(item_row(SAMPLE_MAX, SAMPLE_MIN, 1'b1, pidaw_pkg::DATA_MAX));
      drill_rows.push_back(item_row(SAMPLE_MIN, SAMPLE_MAX, 1'b1, pidaw_pkg::DATA_MIN));
      drill_rows.push_back(item_row(16'sd1, 16'sd0, 1'b1, 32'sh0001_0000));
      // Output clamped to the effort limits.
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_EFFORT_UPPER, 32'h0005_0000));
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_EFFORT_LOWER, 32'hFFFD_0000));
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_CONTROL_MODE,
                                   mode_word(pidaw_pkg::WINDUP_NONE, 1'b1)));
      drill_rows.push_back(item_row(16'sd100, 16'sd0, 1'b1, 32'sh0005_0000));
      drill_rows.push_back(item_row(-16'sd100, 16'sd0, 1'b1, 32'shFFFD_0000));
      // Crossed effort limits: the upper limit is checked first and wins here.
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_EFFORT_UPPER, 32'hFFFF_0000));
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_EFFORT_LOWER, 32'h0001_0000));
      drill_rows.push_back(item_row(16'sd0, 16'sd0, 1'b1, 32'shFFFF_0000));
      // Drive the error sum near its top with a clamp bound, then overflow it.
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_PROP_GAIN, 32'h0));
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_INTEG_GAIN, 32'h0001_0000));
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_DERIV_GAIN, 32'h0000_8000));
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_EFFORT_UPPER, pidaw_pkg::DATA_MAX));
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_EFFORT_LOWER, pidaw_pkg::DATA_MIN));
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_SUM_LOWER, 32'h7FFF_FFF0));
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_CONTROL_MODE,
                                   mode_word(pidaw_pkg::WINDUP_CLAMP, 1'b0)));
      drill_rows.push_back(item_row(16'sd5, 16'sd2, 1'b0, '0));
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_CONTROL_MODE,
                                   mode_word(pidaw_pkg::WINDUP_NONE, 1'b0)));
      drill_rows.push_back(item_row(SAMPLE_MAX, SAMPLE_MIN, 1'b0, '0));
      drill_rows.push_back(item_row(16'sd20, -16'sd20, 1'b0, '0));
      // The same from the bottom.
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_SUM_UPPER, 32'h8000_0010));
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_SUM_LOWER, pidaw_pkg::DATA_MIN));
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_CONTROL_MODE,
                                   mode_word(pidaw_pkg::WINDUP_CLAMP, 1'b0)));
      drill_rows.push_back(item_row(16'sd0, 16'sd0, 1'b0, '0));
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_CONTROL_MODE,
                                   mode_word(pidaw_pkg::WINDUP_NONE, 1'b0)));
      drill_rows.push_back(item_row(SAMPLE_MIN, SAMPLE_MAX, 1'b0, '0));
      // Crossed sum bounds with the output clamped.
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_SUM_UPPER, -32'sd100));
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_SUM_LOWER, 32'd100));
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_EFFORT_UPPER, 32'h0040_0000));
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_EFFORT_LOWER, 32'hFFC0_0000));
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_CONTROL_MODE,
                                   mode_word(pidaw_pkg::WINDUP_CLAMP, 1'b1)));
      drill_rows.push_back(item_row(16'sd3, 16'sd1, 1'b0, '0));
      // Conditional integration inside and outside the limits.
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_PROP_GAIN, 32'h0002_0000));
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_INTEG_GAIN, 32'h0000_1000));
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_DERIV_GAIN, 32'h0));
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_EFFORT_UPPER, 32'h0010_0000));
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_EFFORT_LOWER, 32'hFFF0_0000));
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_CONTROL_MODE,
                                   mode_word(pidaw_pkg::WINDUP_COND, 1'b1)));
      drill_rows.push_back(item_row(16'sd4, 16'sd0, 1'b0, '0));
      drill_rows.push_back(item_row(16'sd20, 16'sd0, 1'b0, '0));
      drill_rows.push_back(item_row(-16'sd20, 16'sd0, 1'b0, '0));
      drill_rows.push_back(item_row(-16'sd1, 16'sd0, 1'b0, '0));
      drill_rows.push_back(item_row(16'sd1, 16'sd0, 1'b0, '0));
      // The unused windup selector behaves as no windup.
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_CONTROL_MODE,
                                   mode_word(WINDUP_UNUSED, 1'b1)));
      drill_rows.push_back(item_row(16'sd7, -16'sd3, 1'b0, '0));
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_CONTROL_MODE,
                                   mode_word(WINDUP_UNUSED, 1'b0)));
      drill_rows.push_back(item_row(-16'sd9, 16'sd4, 1'b0, '0));
      // Extreme gains of both signs.
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_PROP_GAIN, pidaw_pkg::DATA_MIN));
      drill_rows.push_back(cfg_row(pidaw_pkg::CSR_DERIV_GAIN, pidaw_pkg::DATA_MAX));
      drill_rows.push_back(item_row(SAMPLE_MAX, SAMPLE_MIN, 1'b0, '0));
      drill_rows.push_back(item_row(SAMPLE_MIN, SAMPLE_MAX, 1'b0, '0));

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (drill_rows[i]) begin
         if (drill_rows[i].is_cfg) begin
            if (!cfg_open) begin
               wait_idle();
               cfg_open = 1'b1;
            end
            write_csr(drill_rows[i].reg_index, drill_rows[i].data);
         end else begin
            if (cfg_open) begin
               csr_valid <= 1'b0;
               cfg_open = 1'b0;
            end
            send_sample(drill_rows[i].setpoint, drill_rows[i].feedback,
                        drill_rows[i].known, drill_rows[i].effort);
         end
      end

      for (int p = 0; p < 11; p++) begin
         if (p == 4) begin
            send_gap_pct = 49;
            rsp_stall_pct = 12;
         end
         if (p == 8) begin
            send_gap_pct = 0;
            rsp_stall_pct = 0;
         end
         run_random_phase(PHASE_ITEMS, p == 2 || p == 9, p == 6);
      end

      req_valid <= 1'b0;
      while (effort_q.size() != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS pid_antiwindup_controller");
      end else begin
         $display("FAIL pid_antiwindup_controller");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+design
design/pidaw_pkg.sv
design/pidaw_csr.sv
design/pidaw_front.sv
design/pidaw_integ.sv
design/pidaw_out.sv
design/pid_antiwindup_controller.sv
design/pidaw_checker.sv
tb/tb_pid_antiwindup_controller.sv
